### rtl/scfh_pkg.sv
// Shared types and constants of the serial command frame handler.
`default_nettype none

package scfh_pkg;

   // Frame codes and identifiers
   localparam logic [15:0] HOST_ID           = 16'd254;
   localparam logic [7:0]  CMD_VERSION       = 8'hF0;
   localparam logic [7:0]  CMD_UPGRADE_START = 8'hF1;
   localparam logic [7:0]  CMD_UPGRADE_DATA  = 8'hF2;
   localparam logic [7:0]  CMD_UPGRADE_END   = 8'hF3;
   localparam logic [7:0]  BUS_RATE_COMMAND  = 8'd245;
   localparam logic [7:0]  LINE_RATE_COMMAND = 8'd246;

   // Upgrade password and reply constants
   localparam logic [15:0] PW_MULT          = 16'h1234;
   localparam logic [15:0] PW_MASK          = 16'hABCD;
   localparam logic [7:0]  MAX_DATA_LEN     = 8'h08;
   localparam logic [7:0]  UPGRADE_MIN_LEN  = 8'd7;
   localparam logic [3:0]  VERSION_REPLY_LEN = 4'd8;
   localparam logic [3:0]  UPGRADE_REPLY_LEN = 4'd5;

   // Version text layout
   localparam int VERSION_MAX_CHARS = 16;
   localparam int PIECE_CHARS       = 6;
   localparam int PIECE_BITS        = PIECE_CHARS * 8;
   localparam int RESULT_LIMIT      = 3;
   localparam int TEXT_CHARS        = RESULT_LIMIT * PIECE_CHARS;
   localparam int STORE_CHARS       = 16;
   localparam int SPAN_CHARS        = (TEXT_CHARS > STORE_CHARS) ? TEXT_CHARS : STORE_CHARS;
   localparam int SEQ_BITS          = 7;
   localparam int FRAME_BITS        = 2;

   // Register indexes
   localparam logic [1:0] CSR_DEVICE_ID    = 2'd0;
   localparam logic [1:0] CSR_VERSION_LOW  = 2'd1;
   localparam logic [1:0] CSR_VERSION_HIGH = 2'd2;
   localparam logic [1:0] CSR_VERSION_LEN  = 2'd3;

   // Rate kind codes
   localparam logic [1:0] RATE_NONE   = 2'd0;
   localparam logic [1:0] RATE_BUS    = 2'd1;
   localparam logic [1:0] RATE_SERIAL = 2'd2;

   // Command command queue depth
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      KIND_VERSION,
      KIND_UPGRADE,
      KIND_BUS_RATE,
      KIND_LINE_RATE
   } cmd_kind_type;

   // Classified command handed from front to back
   typedef struct packed {
      cmd_kind_type kind;
      logic         match;
      logic [55:0]  args;
   } cmd_type;

   // One result item
   typedef struct packed {
      logic        reply_present;
      logic [63:0] reply_bytes;
      logic [3:0]  reply_length;
      logic        last_of_run;
      logic        enter_bootloader;
      logic        save_settings;
      logic [23:0] control_rate;
      logic [31:0] data_rate;
      logic [31:0] serial_rate;
      logic [1:0]  rate_kind;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/serial_command_frame_handler_top.sv
// Top level of the serial command frame handler: registers, front, queue and back.
//
//   channel  direction  handshake        payload
//   req      in         push / full      sender_identifier, frame_length, frame_bytes
//   rsp      out        pop / empty      reply fields, last_of_run, rates, rate_kind
//   csr      in         csr_write_enable csr_index, csr_data (64 bit)
//
// A frame is classified and registered in the front stage, then waits in a
// two-entry command queue. The back stage emits one result per cycle while
// pop keeps draining its output register: a version query gives one to three
// results, every other kept frame gives one.
// Reset clears the control state and the registers; a stalled pop backs up
// the output register, the queue and then full, without losing items.
`default_nettype none

module serial_command_frame_handler_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [15:0] req_sender_identifier,
   input  wire logic [7:0]  req_frame_length,
   input  wire logic [63:0] req_frame_bytes,
   output logic             empty,
   input  wire logic        pop,
   output logic             rsp_reply_present,
   output logic [63:0]      rsp_reply_bytes,
   output logic [3:0]       rsp_reply_length,
   output logic             rsp_last_of_run,
   output logic             rsp_enter_bootloader,
   output logic             rsp_save_settings,
   output logic [23:0]      rsp_control_rate,
   output logic [31:0]      rsp_data_rate,
   output logic [31:0]      rsp_serial_rate,
   output logic [1:0]       rsp_rate_kind,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   logic [15:0]       device_id_ff;
   logic [63:0]       version_low_ff;
   logic [63:0]       version_high_ff;
   logic [4:0]        version_len_ff;
   logic [15:0]       password;
   logic [31:0]       pw_product;

   logic              q_push, q_ready;
   scfh_pkg::cmd_type q_wr_cmd;
   logic              q_valid, q_take;
   scfh_pkg::cmd_type q_rd_cmd;
   logic              out_valid;
   scfh_pkg::rsp_type out_rsp;

   // Write the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff    <= '0;
         version_low_ff  <= '0;
         version_high_ff <= '0;
         version_len_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            scfh_pkg::CSR_DEVICE_ID:    device_id_ff    <= csr_data[15:0];
            scfh_pkg::CSR_VERSION_LOW:  version_low_ff  <= csr_data;
            scfh_pkg::CSR_VERSION_HIGH: version_high_ff <= csr_data;
            scfh_pkg::CSR_VERSION_LEN:  version_len_ff  <= csr_data[4:0];
            default: begin
            end
         endcase
      end
   end

   // Derive the upgrade password from the device identifier
   assign pw_product = 32'(device_id_ff) * 32'(scfh_pkg::PW_MULT);
   assign password   = pw_product[15:0] ^ scfh_pkg::PW_MASK;

   scfh_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .sender_identifier (req_sender_identifier),
      .frame_length      (req_frame_length),
      .frame_bytes       (req_frame_bytes),
      .password          (password),
      .q_ready           (q_ready),
      .q_push            (q_push),
      .q_cmd             (q_wr_cmd)
   );

   scfh_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (q_push),
      .wr_ready (q_ready),
      .wr_cmd   (q_wr_cmd),
      .rd_valid (q_valid),
      .rd_take  (q_take),
      .rd_cmd   (q_rd_cmd)
   );

   scfh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (q_valid),
      .cmd_take       (q_take),
      .cmd            (q_rd_cmd),
      .password       (password),
      .version_text   ({version_high_ff, version_low_ff}),
      .version_length (version_len_ff),
      .out_valid      (out_valid),
      .out_take       (pop),
      .out_rsp        (out_rsp)
   );

   // Drive the result ports
   assign empty                = !out_valid;
   assign rsp_reply_present    = out_rsp.reply_present;
   assign rsp_reply_bytes      = out_rsp.reply_bytes;
   assign rsp_reply_length     = out_rsp.reply_length;
   assign rsp_last_of_run      = out_rsp.last_of_run;
   assign rsp_enter_bootloader = out_rsp.enter_bootloader;
   assign rsp_save_settings    = out_rsp.save_settings;
   assign rsp_control_rate     = out_rsp.control_rate;
   assign rsp_data_rate        = out_rsp.data_rate;
   assign rsp_serial_rate      = out_rsp.serial_rate;
   assign rsp_rate_kind        = out_rsp.rate_kind;

   // A reply frame never also carries a rate update
   a_reply_xor_rate: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_reply_present && rsp_save_settings))
      else $error("reply and rate update in one result");

   // A bootloader request only comes on the single upgrade reply
   a_boot_on_upgrade: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_enter_bootloader) |->
         (rsp_reply_present && rsp_last_of_run &&
          rsp_reply_length == scfh_pkg::UPGRADE_REPLY_LEN))
      else $error("bootloader request outside an upgrade reply");

   // A non-final version frame is followed by the next sequence number
   a_version_seq: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && rsp_reply_present && !rsp_last_of_run) |=>
         (!empty && rsp_reply_present &&
          rsp_reply_bytes[14:8] == $past(rsp_reply_bytes[14:8]) + 7'd1))
      else $error("version frame sequence broken");

endmodule

`default_nettype wire

### rtl/scfh_front.sv
// Front stage: accept frames, classify them and drop those that give no result.
`default_nettype none

module scfh_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   output logic                      full,
   input  wire logic [15:0]          sender_identifier,
   input  wire logic [7:0]           frame_length,
   input  wire logic [63:0]          frame_bytes,
   input  wire logic [15:0]          password,
   input  wire logic                 q_ready,
   output logic                      q_push,
   output scfh_pkg::cmd_type         q_cmd
);

   logic              valid_ff, valid_in;
   scfh_pkg::cmd_type cmd_ff, cmd_in;
   logic              keep;
   logic              accept;
   logic [7:0]        code;
   logic              fixed_code;

   assign code       = frame_bytes[7:0];
   assign fixed_code = (code == scfh_pkg::CMD_VERSION) ||
                       (code == scfh_pkg::CMD_UPGRADE_START) ||
                       (code == scfh_pkg::CMD_UPGRADE_DATA) ||
                       (code == scfh_pkg::CMD_UPGRADE_END);

   // Classify the incoming frame
   always_comb begin
      keep         = 1'b0;
      cmd_in.kind  = scfh_pkg::KIND_VERSION;
      cmd_in.args  = frame_bytes[63:8];
      cmd_in.match = ({frame_bytes[47:40], frame_bytes[39:32]} == password);
      if (frame_length != 8'd0) begin
         if (fixed_code) begin
            if (sender_identifier == scfh_pkg::HOST_ID) begin
               if (code == scfh_pkg::CMD_VERSION) begin
                  keep        = 1'b1;
                  cmd_in.kind = scfh_pkg::KIND_VERSION;
               end else if (code == scfh_pkg::CMD_UPGRADE_START &&
                            frame_length >= scfh_pkg::UPGRADE_MIN_LEN) begin
                  keep        = 1'b1;
                  cmd_in.kind = scfh_pkg::KIND_UPGRADE;
               end
            end
         end else if (code == scfh_pkg::BUS_RATE_COMMAND) begin
            keep        = 1'b1;
            cmd_in.kind = scfh_pkg::KIND_BUS_RATE;
         end else if (code == scfh_pkg::LINE_RATE_COMMAND) begin
            keep        = 1'b1;
            cmd_in.kind = scfh_pkg::KIND_LINE_RATE;
         end
      end
   end

   // Hold a classified command until the queue takes it
   assign full   = valid_ff && !q_ready;
   assign accept = push && !full;
   assign q_push = valid_ff;
   assign q_cmd  = cmd_ff;

   always_comb begin
      if (accept) begin
         valid_in = keep;
      end else begin
         valid_in = valid_ff && !q_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

`default_nettype wire

### rtl/scfh_cmd_queue.sv
// Short queue of classified commands between front and back.
`default_nettype none

module scfh_cmd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_valid,
   output logic                   wr_ready,
   input  wire scfh_pkg::cmd_type wr_cmd,
   output logic                   rd_valid,
   input  wire logic              rd_take,
   output scfh_pkg::cmd_type      rd_cmd
);

   localparam int PTR_BITS = (scfh_pkg::QUEUE_DEPTH > 1) ? $clog2(scfh_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(scfh_pkg::QUEUE_DEPTH + 1);

   scfh_pkg::cmd_type   slot_ff [scfh_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_wr, do_rd;

   assign wr_ready = (count_ff != CNT_BITS'(scfh_pkg::QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_cmd   = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_take && rd_valid;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(scfh_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(scfh_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store an entry on each transfer in
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

`default_nettype wire

### rtl/scfh_back.sv
// Back stage: expand each command into its result items behind an output register.
`default_nettype none

module scfh_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   output logic                   cmd_take,
   input  wire scfh_pkg::cmd_type cmd,
   input  wire logic [15:0]       password,
   input  wire logic [127:0]      version_text,
   input  wire logic [4:0]        version_length,
   output logic                   out_valid,
   input  wire logic              out_take,
   output scfh_pkg::rsp_type      out_rsp
);

   localparam int SPAN_BITS = scfh_pkg::SPAN_CHARS * 8;

   logic [scfh_pkg::FRAME_BITS-1:0] frame_ff, frame_in;
   logic                            valid_ff, valid_in;
   scfh_pkg::rsp_type               rsp_ff, rsp_in;
   logic                            load;
   logic                            last;
   logic                            version_tail;
   logic [4:0]                      vlen;
   logic [5:0]                      piece_end;
   logic [SPAN_BITS-1:0]            text_ext;
   logic [SPAN_BITS-1:0]            text_masked;
   logic [scfh_pkg::PIECE_BITS-1:0] piece;
   logic [47:0]                     piece_pad;

   // Clamp the version length to one through the maximum
   always_comb begin
      if (version_length == 5'd0) begin
         vlen = 5'd1;
      end else if (version_length > 5'(scfh_pkg::VERSION_MAX_CHARS)) begin
         vlen = 5'(scfh_pkg::VERSION_MAX_CHARS);
      end else begin
         vlen = version_length;
      end
   end

   // Zero characters past the length, then pick this frame's piece
   assign text_ext = SPAN_BITS'(version_text);

   always_comb begin
      for (int k = 0; k < scfh_pkg::SPAN_CHARS; k++) begin
         text_masked[k*8 +: 8] = (k < int'(vlen)) ? text_ext[k*8 +: 8] : 8'd0;
      end
   end

   assign piece     = text_masked[int'(frame_ff) * scfh_pkg::PIECE_BITS +: scfh_pkg::PIECE_BITS];
   assign piece_pad = 48'(piece);

   assign piece_end    = (6'(frame_ff) + 6'd1) * 6'(scfh_pkg::PIECE_CHARS);
   assign version_tail = (frame_ff == scfh_pkg::FRAME_BITS'(scfh_pkg::RESULT_LIMIT - 1)) ||
                         (piece_end >= 6'(vlen));
   assign last         = (cmd.kind != scfh_pkg::KIND_VERSION) || version_tail;

   // Build the result for the current command and frame
   always_comb begin
      rsp_in = '0;
      rsp_in.last_of_run = last;
      unique case (cmd.kind)
         scfh_pkg::KIND_VERSION: begin
            rsp_in.reply_present = 1'b1;
            rsp_in.reply_length  = scfh_pkg::VERSION_REPLY_LEN;
            rsp_in.reply_bytes   = {piece_pad, version_tail,
                                    scfh_pkg::SEQ_BITS'(frame_ff), scfh_pkg::CMD_VERSION};
         end
         scfh_pkg::KIND_UPGRADE: begin
            rsp_in.reply_present    = 1'b1;
            rsp_in.reply_length     = scfh_pkg::UPGRADE_REPLY_LEN;
            rsp_in.enter_bootloader = cmd.match;
            rsp_in.reply_bytes      = {24'd0, scfh_pkg::MAX_DATA_LEN, password,
                                       7'd0, cmd.match, scfh_pkg::CMD_UPGRADE_START};
         end
         scfh_pkg::KIND_BUS_RATE: begin
            rsp_in.save_settings = 1'b1;
            rsp_in.control_rate  = cmd.args[23:0];
            rsp_in.data_rate     = cmd.args[55:24];
            rsp_in.rate_kind     = scfh_pkg::RATE_BUS;
         end
         scfh_pkg::KIND_LINE_RATE: begin
            rsp_in.save_settings = 1'b1;
            rsp_in.serial_rate   = cmd.args[31:0];
            rsp_in.rate_kind     = scfh_pkg::RATE_SERIAL;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // Load the output register when it is free or being drained
   assign load     = cmd_valid && (!valid_ff || out_take);
   assign cmd_take = load && last;
   assign valid_in = load || (valid_ff && !out_take);

   always_comb begin
      frame_in = frame_ff;
      if (load) begin
         frame_in = last ? '0 : frame_ff + scfh_pkg::FRAME_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         frame_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         frame_ff <= frame_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

`default_nettype wire

### tb/serial_command_frame_handler_top_test.sv
// Self-checking testbench for the serial command frame handler top level.
`timescale 1ns / 1ps

module serial_command_frame_handler_top_test;

   localparam int CLOCK_PERIOD  = 4;
   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 400;
   localparam int TIMEOUT_NS    = 2_000_000;

   typedef struct packed {
      logic [15:0] ident;
      logic [7:0]  len;
      logic [63:0] bytes;
   } frame_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [15:0] req_sender_identifier = '0;
   logic [7:0]  req_frame_length = '0;
   logic [63:0] req_frame_bytes = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_reply_present;
   logic [63:0] rsp_reply_bytes;
   logic [3:0]  rsp_reply_length;
   logic        rsp_last_of_run;
   logic        rsp_enter_bootloader;
   logic        rsp_save_settings;
   logic [23:0] rsp_control_rate;
   logic [31:0] rsp_data_rate;
   logic [31:0] rsp_serial_rate;
   logic [1:0]  rsp_rate_kind;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   // Shadow copy of the registers
   logic [15:0] cfg_device_id = '0;
   logic [63:0] cfg_text_low = '0;
   logic [63:0] cfg_text_high = '0;
   logic [4:0]  cfg_version_len = '0;

   frame_type         pending_frames[$];
   scfh_pkg::rsp_type expected_replies[$];
   int                error_count = 0;
   int unsigned       send_idle_pct = 0;
   int unsigned       recv_stall_pct = 0;
   logic              req_taken = 1'b0;
   logic              pressure_go = 1'b0;
   logic              pressure_used = 1'b0;
   int                hold_left = 0;

   serial_command_frame_handler_top uut (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_sender_identifier(req_sender_identifier),
      .req_frame_length     (req_frame_length),
      .req_frame_bytes      (req_frame_bytes),
      .empty                (empty),
      .pop                  (pop),
      .rsp_reply_present    (rsp_reply_present),
      .rsp_reply_bytes      (rsp_reply_bytes),
      .rsp_reply_length     (rsp_reply_length),
      .rsp_last_of_run      (rsp_last_of_run),
      .rsp_enter_bootloader (rsp_enter_bootloader),
      .rsp_save_settings    (rsp_save_settings),
      .rsp_control_rate     (rsp_control_rate),
      .rsp_data_rate        (rsp_data_rate),
      .rsp_serial_rate      (rsp_serial_rate),
      .rsp_rate_kind        (rsp_rate_kind),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Upgrade password derived from the device identifier
   function automatic logic [15:0] upgrade_password();
      logic [15:0] pw;
      pw = (cfg_device_id * scfh_pkg::PW_MULT) ^ scfh_pkg::PW_MASK;
      return pw;
   endfunction

   // Work out the replies one accepted frame causes and queue them
   task automatic predict_replies(input frame_type fr);
      scfh_pkg::rsp_type r;
      logic [7:0]        code;
      logic [127:0]      text;
      logic [15:0]       pw;
      logic              match;
      int                chars;
      int                pieces;
      int                pos;
      int                f;
      int                j;
      code = fr.bytes[7:0];
      text = {cfg_text_high, cfg_text_low};
      r = '0;
      if (fr.len == 8'd0) return;
      if (code == scfh_pkg::CMD_VERSION || code == scfh_pkg::CMD_UPGRADE_START ||
          code == scfh_pkg::CMD_UPGRADE_DATA || code == scfh_pkg::CMD_UPGRADE_END) begin
         if (fr.ident != scfh_pkg::HOST_ID) return;
         if (code == scfh_pkg::CMD_VERSION) begin
            chars = (cfg_version_len == 5'd0) ? 1 : int'(cfg_version_len);
            if (chars > scfh_pkg::VERSION_MAX_CHARS) chars = scfh_pkg::VERSION_MAX_CHARS;
            pieces = (chars + scfh_pkg::PIECE_CHARS - 1) / scfh_pkg::PIECE_CHARS;
            if (pieces > scfh_pkg::RESULT_LIMIT) pieces = scfh_pkg::RESULT_LIMIT;
            for (f = 0; f < pieces; f++) begin
               r = '0;
               r.reply_present = 1'b1;
               r.reply_bytes[7:0] = scfh_pkg::CMD_VERSION;
               r.reply_bytes[15:8] = {1'(f == pieces - 1), 7'(f)};
               for (j = 0; j < scfh_pkg::PIECE_CHARS; j++) begin
                  pos = f * scfh_pkg::PIECE_CHARS + j;
                  if (pos < chars) r.reply_bytes[(2 + j) * 8 +: 8] = text[pos * 8 +: 8];
               end
               r.reply_length = scfh_pkg::VERSION_REPLY_LEN;
               r.last_of_run = (f == pieces - 1);
               expected_replies.push_back(r);
            end
         end else if (code == scfh_pkg::CMD_UPGRADE_START &&
                      fr.len >= scfh_pkg::UPGRADE_MIN_LEN) begin
            pw = upgrade_password();
            match = (fr.bytes[47:32] == pw);
            r.reply_present = 1'b1;
            r.reply_bytes = {24'd0, scfh_pkg::MAX_DATA_LEN, pw, 7'd0, match,
                             scfh_pkg::CMD_UPGRADE_START};
            r.reply_length = scfh_pkg::UPGRADE_REPLY_LEN;
            r.last_of_run = 1'b1;
            r.enter_bootloader = match;
            expected_replies.push_back(r);
         end
      end else if (code == scfh_pkg::BUS_RATE_COMMAND) begin
         r.last_of_run = 1'b1;
         r.save_settings = 1'b1;
         r.control_rate = fr.bytes[31:8];
         r.data_rate = fr.bytes[63:32];
         r.rate_kind = scfh_pkg::RATE_BUS;
         expected_replies.push_back(r);
      end else if (code == scfh_pkg::LINE_RATE_COMMAND) begin
         r.last_of_run = 1'b1;
         r.save_settings = 1'b1;
         r.serial_rate = fr.bytes[39:8];
         r.rate_kind = scfh_pkg::RATE_SERIAL;
         expected_replies.push_back(r);
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   // Drive frames at the falling edge; hold an offer until it transfers
   always @(negedge clock) begin : frame_driver
      frame_type fr;
      if (reset) begin
         push <= 1'b0;
      end else if (!push || req_taken) begin
         if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            fr = pending_frames.pop_front();
            push <= 1'b1;
            req_sender_identifier <= fr.ident;
            req_frame_length <= fr.len;
            req_frame_bytes <= fr.bytes;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // Count down the long receiver hold-off
   always @(negedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (pressure_go && !pressure_used) begin
         hold_left <= HOLD_CYCLES;
         pressure_used <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Drive pop with random stalls
   always @(negedge clock) begin
      if (reset) pop <= 1'b0;
      else pop <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
   end

   // Sample both channels at the rising edge: check replies, then predict new ones
   always @(posedge clock) begin : transfer_monitor
      scfh_pkg::rsp_type want;
      if (!reset && pop && !empty) begin
         if (expected_replies.size() == 0) begin
            $error("reply transfer with no reply expected");
            error_count++;
         end else begin
            want = expected_replies.pop_front();
            check_field("reply_present", 64'(want.reply_present), 64'(rsp_reply_present));
            check_field("reply_bytes", want.reply_bytes, rsp_reply_bytes);
            check_field("reply_length", 64'(want.reply_length), 64'(rsp_reply_length));
            check_field("last_of_run", 64'(want.last_of_run), 64'(rsp_last_of_run));
            check_field("enter_bootloader", 64'(want.enter_bootloader),
                        64'(rsp_enter_bootloader));
            check_field("save_settings", 64'(want.save_settings), 64'(rsp_save_settings));
            check_field("control_rate", 64'(want.control_rate), 64'(rsp_control_rate));
            check_field("data_rate", 64'(want.data_rate), 64'(rsp_data_rate));
            check_field("serial_rate", 64'(want.serial_rate), 64'(rsp_serial_rate));
            check_field("rate_kind", 64'(want.rate_kind), 64'(rsp_rate_kind));
         end
      end
      req_taken <= !reset && push && !full;
      if (!reset && push && !full)
         predict_replies({req_sender_identifier, req_frame_length, req_frame_bytes});
   end

   task automatic add_frame(input logic [15:0] ident, input logic [7:0] len,
                            input logic [63:0] bytes);
      pending_frames.push_back({ident, len, bytes});
   endtask

   // Random frame: mostly well-formed commands, the rest noise
   function automatic frame_type make_frame();
      frame_type   fr;
      int unsigned sel;
      sel = $urandom_range(99);
      fr.ident = 16'($urandom);
      fr.len = 8'($urandom);
      fr.bytes = {$urandom, $urandom};
      if (sel < 30) begin
         fr.ident = scfh_pkg::HOST_ID;
         fr.len = 8'($urandom_range(1, 255));
         fr.bytes[7:0] = scfh_pkg::CMD_VERSION;
      end else if (sel < 55) begin
         fr.ident = scfh_pkg::HOST_ID;
         fr.bytes[7:0] = scfh_pkg::CMD_UPGRADE_START;
         fr.len = ($urandom_range(9) == 0) ? 8'($urandom_range(6)) :
                                             8'($urandom_range(7, 255));
         if ($urandom_range(1) == 1) fr.bytes[47:32] = upgrade_password();
      end else if (sel < 70) begin
         fr.bytes[7:0] = scfh_pkg::BUS_RATE_COMMAND;
      end else if (sel < 85) begin
         fr.bytes[7:0] = scfh_pkg::LINE_RATE_COMMAND;
      end else if (sel < 92) begin
         // fixed command codes, identifier mostly wrong
         fr.bytes[7:0] = scfh_pkg::CMD_VERSION + 8'($urandom_range(3));
         if ($urandom_range(3) == 0) fr.ident = scfh_pkg::HOST_ID;
      end
      return fr;
   endfunction

   task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         scfh_pkg::CSR_DEVICE_ID:    cfg_device_id = value[15:0];
         scfh_pkg::CSR_VERSION_LOW:  cfg_text_low = value;
         scfh_pkg::CSR_VERSION_HIGH: cfg_text_high = value;
         scfh_pkg::CSR_VERSION_LEN:  cfg_version_len = value[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(input logic [15:0] dev, input logic [63:0] low,
                            input logic [63:0] high, input logic [4:0] len);
      write_reg(scfh_pkg::CSR_DEVICE_ID, 64'(dev));
      write_reg(scfh_pkg::CSR_VERSION_LOW, low);
      write_reg(scfh_pkg::CSR_VERSION_HIGH, high);
      write_reg(scfh_pkg::CSR_VERSION_LEN, 64'(len));
      @(posedge clock);
   endtask

   // Wait until every frame has transferred, every reply arrived and the block is idle
   task automatic settle_all();
      while (pending_frames.size() != 0 || push) @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int count, input int unsigned send_pct,
                            input int unsigned recv_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      repeat (count) pending_frames.push_back(make_frame());
      settle_all();
   endtask

   // Stimulus sequence
   initial begin
      logic [15:0] pw;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset register values: version length zero, password of identifier zero
      add_frame(scfh_pkg::HOST_ID, 8'd1, {56'd0, scfh_pkg::CMD_VERSION});
      add_frame(scfh_pkg::HOST_ID, 8'd7,
                {16'd0, upgrade_password(), 24'd0, scfh_pkg::CMD_UPGRADE_START});
      settle_all();

      configure(16'h1357, {$urandom, $urandom}, {$urandom, $urandom}, 5'd16);
      pw = upgrade_password();
      // Empty frame, full version text, wrong identifiers
      add_frame(scfh_pkg::HOST_ID, 8'd0, {56'd0, scfh_pkg::CMD_VERSION});
      add_frame(scfh_pkg::HOST_ID, 8'd255, {56'hFF_FFFF_FFFF_FFFF, scfh_pkg::CMD_VERSION});
      add_frame(16'd253, 8'd1, {56'd0, scfh_pkg::CMD_VERSION});
      add_frame(16'hFFFF, 8'd8, {56'd0, scfh_pkg::CMD_VERSION});
      add_frame(16'd0, 8'd7, {16'd0, pw, 24'd0, scfh_pkg::CMD_UPGRADE_START});
      // Upgrade: match, mismatch, short request, longest frame
      add_frame(scfh_pkg::HOST_ID, 8'd7, {16'd0, pw, 24'd0, scfh_pkg::CMD_UPGRADE_START});
      add_frame(scfh_pkg::HOST_ID, 8'd8,
                {16'd0, pw ^ 16'd1, 24'd0, scfh_pkg::CMD_UPGRADE_START});
      add_frame(scfh_pkg::HOST_ID, 8'd6, {16'd0, pw, 24'd0, scfh_pkg::CMD_UPGRADE_START});
      add_frame(scfh_pkg::HOST_ID, 8'd255,
                {16'hFFFF, pw, 24'hFF_FFFF, scfh_pkg::CMD_UPGRADE_START});
      add_frame(scfh_pkg::HOST_ID, 8'd2, {56'd0, scfh_pkg::CMD_UPGRADE_DATA});
      add_frame(scfh_pkg::HOST_ID, 8'd3, {56'd0, scfh_pkg::CMD_UPGRADE_END});
      // Rate commands: any identifier, length ignored but for zero
      add_frame(16'd0, 8'd1, {56'hFF_FFFF_FFFF_FFFF, scfh_pkg::BUS_RATE_COMMAND});
      add_frame(16'hFFFF, 8'd0, {56'hFF_FFFF_FFFF_FFFF, scfh_pkg::BUS_RATE_COMMAND});
      add_frame(scfh_pkg::HOST_ID, 8'd255, {56'd0, scfh_pkg::BUS_RATE_COMMAND});
      add_frame(16'h8000, 8'd1, {56'hFF_FFFF_FFFF_FFFF, scfh_pkg::LINE_RATE_COMMAND});
      add_frame(scfh_pkg::HOST_ID, 8'd255, {56'd0, scfh_pkg::LINE_RATE_COMMAND});
      // Unknown commands
      add_frame(scfh_pkg::HOST_ID, 8'd255, {56'hFF_FFFF_FFFF_FFFF, 8'hFF});
      add_frame(scfh_pkg::HOST_ID, 8'd1, 64'd0);
      add_frame(16'd1, 8'd4, {56'hA5_A5A5_A5A5_A5A5, 8'h7F});
      settle_all();

      // Random phases over several register settings and idling patterns
      configure(16'hFFFF, {64{1'b1}}, {64{1'b1}}, 5'd31);
      run_phase(70, 0, 0);
      configure(16'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                5'($urandom_range(16)));
      run_phase(70, 77, 0);
      configure(16'd0, 64'd0, 64'd0, 5'd0);
      run_phase(70, 0, 77);
      configure(16'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                5'($urandom_range(1, 31)));
      run_phase(70, 30, 30);

      // Back-pressure: the receiver holds off while frames keep coming
      configure(16'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                5'($urandom_range(7, 16)));
      @(posedge clock);
      pressure_go = 1'b1;
      run_phase(70, 0, 0);

      if (error_count == 0) begin
         $display("serial_command_frame_handler_top_test: PASS");
      end else begin
         $display("serial_command_frame_handler_top_test: FAIL");
      end
      $finish;
   end

   // Timeout guard
   initial begin
      #(TIMEOUT_NS);
      $display("serial_command_frame_handler_top_test: FAIL");
      $finish;
   end

endmodule
